>>> src/dltr_pkg.sv
// Shared types and constants for the DDA line and triangle rasterizer.
package dltr_pkg;

    localparam int COORD_BITS_DEF = 16;
    localparam int FRAC_BITS_DEF  = 16;
    localparam int MAX_DIM_DEF    = 4096;

    localparam int KIND_BITS      = 2;
    localparam int COLOR_BITS     = 32;
    localparam int INDEX_BITS     = 24;
    localparam int CFG_DATA_BITS  = 13;
    localparam int CFG_INDEX_BITS = 1;
    localparam int QUEUE_DEPTH    = 2;

    localparam int WIDTH_RESET    = 800;
    localparam int HEIGHT_RESET   = 600;

    localparam logic [CFG_INDEX_BITS-1:0] REG_SCREEN_WIDTH  = 1'b0;
    localparam logic [CFG_INDEX_BITS-1:0] REG_SCREEN_HEIGHT = 1'b1;

    localparam logic [1:0] EDGE_AB = 2'd0;
    localparam logic [1:0] EDGE_BC = 2'd1;
    localparam logic [1:0] EDGE_CA = 2'd2;

    typedef enum logic [KIND_BITS-1:0] {
        KIND_TICK = 2'd0,
        KIND_LINE = 2'd1,
        KIND_TRI  = 2'd2
    } kind_t;

    typedef enum logic [1:0] {
        ST_IDLE  = 2'd0,
        ST_SETUP = 2'd1,
        ST_DIV   = 2'd2,
        ST_RUN   = 2'd3
    } core_state_t;

    typedef struct packed {
        logic  valid;
        kind_t kind;
    } q_head_t;

endpackage

>>> src/dltr_front.sv
// Front end: accepts command beats, drops reserved kinds, queues the rest.
module dltr_front import dltr_pkg::*; #(
    parameter int COORD_BITS = COORD_BITS_DEF
) (
    input  logic                         aclk,
    input  logic                         aresetn,
    input  logic                         s_valid,
    output logic                         s_ready,
    input  logic [KIND_BITS-1:0]         s_kind,
    input  logic [5:0][COORD_BITS-1:0]   s_vtx,
    input  logic [COLOR_BITS-1:0]        s_paint,
    input  logic                         head_pop,
    output q_head_t                      head,
    output logic [5:0][COORD_BITS-1:0]   head_vtx,
    output logic [COLOR_BITS-1:0]        head_paint
);

    localparam int PTR_BITS = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_BITS = $clog2(QUEUE_DEPTH + 1);

    kind_t                       kind_mem  [QUEUE_DEPTH];
    logic [5:0][COORD_BITS-1:0]  vtx_mem   [QUEUE_DEPTH];
    logic [COLOR_BITS-1:0]       paint_mem [QUEUE_DEPTH];

    logic [PTR_BITS-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_BITS-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_BITS-1:0] count_reg, count_next;
    logic                keep;
    logic                push;

    always_comb begin
        case (s_kind)
            KIND_TICK, KIND_LINE, KIND_TRI: keep = 1'b1;
            default: keep = 1'b0;
        endcase
    end

    assign s_ready = (count_reg != CNT_BITS'(QUEUE_DEPTH));
    assign push    = s_valid && s_ready && keep;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (head_pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_BITS'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        case ({push, head_pop})
            2'b10: count_next = count_reg + 1'b1;
            2'b01: count_next = count_reg - 1'b1;
            default: count_next = count_reg;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            kind_mem[wr_ptr_reg]  <= kind_t'(s_kind);
            vtx_mem[wr_ptr_reg]   <= s_vtx;
            paint_mem[wr_ptr_reg] <= s_paint;
        end
    end

    assign head.valid = (count_reg != '0);
    assign head.kind  = kind_mem[rd_ptr_reg];
    assign head_vtx   = vtx_mem[rd_ptr_reg];
    assign head_paint = paint_mem[rd_ptr_reg];

endmodule

>>> src/dltr_div.sv
// Radix-2 restoring divider producing both edge increments, one bit a cycle.
module dltr_div import dltr_pkg::*; #(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  start,
    input  logic [COORD_BITS-1:0] mag_x,
    input  logic [COORD_BITS-1:0] mag_y,
    input  logic [COORD_BITS-1:0] divisor,
    output logic                  done,
    output logic [FRAC_BITS:0]    q_x,
    output logic [FRAC_BITS:0]    q_y
);

    localparam int CB       = COORD_BITS;
    localparam int FB       = FRAC_BITS;
    localparam int CNT_BITS = $clog2(FB + 1);

    logic [CB-1:0]       rem_x_reg, rem_y_reg, d_reg;
    logic [FB:0]         q_x_reg, q_y_reg;
    logic [CNT_BITS-1:0] cnt_reg;
    logic                run_reg, done_reg;
    logic                last_step;
    logic [CB:0]         step_x, step_y;

    // returns {quotient bit, new remainder}
    function automatic logic [CB:0] div_step(input logic [CB-1:0] rem, input logic b,
                                             input logic [CB-1:0] d);
        logic [CB:0] t;
        logic [CB:0] diff;
        t    = {rem, b};
        diff = t - {1'b0, d};
        if (t >= {1'b0, d}) begin
            return {1'b1, diff[CB-1:0]};
        end
        return {1'b0, t[CB-1:0]};
    endfunction

    assign last_step = run_reg && (cnt_reg == CNT_BITS'(FB));
    assign step_x    = div_step(rem_x_reg, q_x_reg[FB], d_reg);
    assign step_y    = div_step(rem_y_reg, q_y_reg[FB], d_reg);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            run_reg  <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            done_reg <= last_step;
            if (start) begin
                run_reg <= 1'b1;
            end else if (last_step) begin
                run_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            d_reg     <= divisor;
            rem_x_reg <= mag_x >> 1;
            rem_y_reg <= mag_y >> 1;
            q_x_reg   <= {mag_x[0], {FB{1'b0}}};
            q_y_reg   <= {mag_y[0], {FB{1'b0}}};
            cnt_reg   <= '0;
        end else if (run_reg) begin
            rem_x_reg <= step_x[CB-1:0];
            rem_y_reg <= step_y[CB-1:0];
            q_x_reg   <= {q_x_reg[FB-1:0], step_x[CB]};
            q_y_reg   <= {q_y_reg[FB-1:0], step_y[CB]};
            cnt_reg   <= cnt_reg + 1'b1;
        end
    end

    assign done = done_reg;
    assign q_x  = q_x_reg;
    assign q_y  = q_y_reg;

endmodule

>>> src/dltr_core.sv
// Back end: edge sequencer, DDA accumulators and pixel rounding stage.
module dltr_core import dltr_pkg::*; #(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  q_head_t                       head,
    input  logic [5:0][COORD_BITS-1:0]    head_vtx,
    input  logic [COLOR_BITS-1:0]         head_paint,
    output logic                          head_pop,
    output logic                          div_start,
    output logic [COORD_BITS-1:0]         div_mag_x,
    output logic [COORD_BITS-1:0]         div_mag_y,
    output logic [COORD_BITS-1:0]         div_n,
    input  logic                          div_done,
    input  logic [FRAC_BITS:0]            div_q_x,
    input  logic [FRAC_BITS:0]            div_q_y,
    output logic                          p1_valid,
    output logic signed [COORD_BITS-1:0]  p1_x,
    output logic signed [COORD_BITS-1:0]  p1_y,
    output logic [COLOR_BITS-1:0]         p1_color,
    output logic                          p1_last,
    input  logic                          p1_take
);

    localparam int CB  = COORD_BITS;
    localparam int FB  = FRAC_BITS;
    localparam int ACC = CB + FB;
    localparam logic [ACC:0] HALF = (ACC + 1)'(1) << (FB - 1);

    core_state_t              state_reg, state_next;
    logic [1:0]               edge_num_reg, edge_num_next;
    logic [5:0][CB-1:0]       v_reg, v_next;
    logic [COLOR_BITS-1:0]    color_reg, color_next;
    logic signed [ACC-1:0]    acc_x_reg, acc_x_next, acc_y_reg, acc_y_next;
    logic signed [ACC-1:0]    inc_x_reg, inc_x_next, inc_y_reg, inc_y_next;
    logic [CB-1:0]            steps_reg, steps_next;
    logic                     neg_x_reg, neg_x_next, neg_y_reg, neg_y_next;
    logic                     p1_valid_reg, p1_valid_next;
    logic signed [CB-1:0]     p1_x_reg, p1_x_next, p1_y_reg, p1_y_next;
    logic [COLOR_BITS-1:0]    p1_color_reg, p1_color_next;
    logic                     p1_last_reg, p1_last_next;

    logic signed [CB-1:0]     x0, y0, x1, y1;
    logic signed [CB:0]       dx, dy;
    logic [CB-1:0]            mag_x, mag_y, n;
    logic [ACC-1:0]           qx_ext, qy_ext;
    logic                     p1_free;
    logic                     is_start;

    function automatic logic [CB-1:0] round_fix(input logic signed [ACC-1:0] a);
        logic [ACC:0] ext;
        logic [ACC:0] mag;
        logic [ACC:0] r;
        ext = (ACC + 1)'(a);
        mag = a[ACC-1] ? (~ext + 1'b1) : ext;
        r   = (mag + HALF) >> FB;
        r   = a[ACC-1] ? (~r + 1'b1) : r;
        return r[CB-1:0];
    endfunction

    always_comb begin
        case (edge_num_reg)
            EDGE_AB: begin
                x0 = v_reg[0]; y0 = v_reg[1]; x1 = v_reg[2]; y1 = v_reg[3];
            end
            EDGE_BC: begin
                x0 = v_reg[2]; y0 = v_reg[3]; x1 = v_reg[4]; y1 = v_reg[5];
            end
            default: begin
                x0 = v_reg[4]; y0 = v_reg[5]; x1 = v_reg[0]; y1 = v_reg[1];
            end
        endcase
    end

    assign dx    = (CB + 1)'(x1) - (CB + 1)'(x0);
    assign dy    = (CB + 1)'(y1) - (CB + 1)'(y0);
    assign mag_x = dx[CB] ? CB'(-dx) : CB'(dx);
    assign mag_y = dy[CB] ? CB'(-dy) : CB'(dy);
    assign n     = (mag_x > mag_y) ? mag_x : mag_y;

    assign div_mag_x = mag_x;
    assign div_mag_y = mag_y;
    assign div_n     = n;

    assign qx_ext  = ACC'(div_q_x);
    assign qy_ext  = ACC'(div_q_y);
    assign p1_free = !p1_valid_reg || p1_take;

    always_comb begin
        case (head.kind)
            KIND_LINE, KIND_TRI: is_start = head.valid;
            default: is_start = 1'b0;
        endcase
    end

    always_comb begin
        state_next    = state_reg;
        edge_num_next = edge_num_reg;
        v_next        = v_reg;
        color_next    = color_reg;
        acc_x_next    = acc_x_reg;
        acc_y_next    = acc_y_reg;
        inc_x_next    = inc_x_reg;
        inc_y_next    = inc_y_reg;
        steps_next    = steps_reg;
        neg_x_next    = neg_x_reg;
        neg_y_next    = neg_y_reg;
        p1_valid_next = p1_valid_reg && !p1_take;
        p1_x_next     = p1_x_reg;
        p1_y_next     = p1_y_reg;
        p1_color_next = p1_color_reg;
        p1_last_next  = p1_last_reg;
        head_pop      = 1'b0;
        div_start     = 1'b0;

        case (state_reg)
            ST_IDLE, ST_RUN: begin
                if (is_start) begin
                    head_pop   = 1'b1;
                    color_next = head_paint;
                    state_next = ST_SETUP;
                    if (head.kind == KIND_LINE) begin
                        // line runs as the closing edge: c->a carries a->b
                        v_next[0]     = head_vtx[2];
                        v_next[1]     = head_vtx[3];
                        v_next[2]     = head_vtx[2];
                        v_next[3]     = head_vtx[3];
                        v_next[4]     = head_vtx[0];
                        v_next[5]     = head_vtx[1];
                        edge_num_next = EDGE_CA;
                    end else begin
                        v_next        = head_vtx;
                        edge_num_next = EDGE_AB;
                    end
                end else if (head.valid && state_reg == ST_IDLE) begin
                    head_pop = 1'b1;
                end else if (head.valid && p1_free) begin
                    head_pop      = 1'b1;
                    p1_valid_next = 1'b1;
                    p1_x_next     = signed'(round_fix(acc_x_reg));
                    p1_y_next     = signed'(round_fix(acc_y_reg));
                    p1_color_next = color_reg;
                    p1_last_next  = 1'b0;
                    if (steps_reg != '0) begin
                        acc_x_next = acc_x_reg + inc_x_reg;
                        acc_y_next = acc_y_reg + inc_y_reg;
                        steps_next = steps_reg - 1'b1;
                    end else if (edge_num_reg != EDGE_CA) begin
                        edge_num_next = edge_num_reg + 1'b1;
                        state_next    = ST_SETUP;
                    end else begin
                        p1_last_next = 1'b1;
                        state_next   = ST_IDLE;
                    end
                end
            end
            ST_SETUP: begin
                acc_x_next = {x0, {FB{1'b0}}};
                acc_y_next = {y0, {FB{1'b0}}};
                steps_next = n;
                neg_x_next = dx[CB];
                neg_y_next = dy[CB];
                if (n == '0) begin
                    inc_x_next = '0;
                    inc_y_next = '0;
                    state_next = ST_RUN;
                end else begin
                    div_start  = 1'b1;
                    state_next = ST_DIV;
                end
            end
            ST_DIV: begin
                if (div_done) begin
                    inc_x_next = neg_x_reg ? -signed'(qx_ext) : signed'(qx_ext);
                    inc_y_next = neg_y_reg ? -signed'(qy_ext) : signed'(qy_ext);
                    state_next = ST_RUN;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            edge_num_reg <= EDGE_AB;
            p1_valid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            edge_num_reg <= edge_num_next;
            p1_valid_reg <= p1_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        v_reg        <= v_next;
        color_reg    <= color_next;
        acc_x_reg    <= acc_x_next;
        acc_y_reg    <= acc_y_next;
        inc_x_reg    <= inc_x_next;
        inc_y_reg    <= inc_y_next;
        steps_reg    <= steps_next;
        neg_x_reg    <= neg_x_next;
        neg_y_reg    <= neg_y_next;
        p1_x_reg     <= p1_x_next;
        p1_y_reg     <= p1_y_next;
        p1_color_reg <= p1_color_next;
        p1_last_reg  <= p1_last_next;
    end

    assign p1_valid = p1_valid_reg;
    assign p1_x     = p1_x_reg;
    assign p1_y     = p1_y_reg;
    assign p1_color = p1_color_reg;
    assign p1_last  = p1_last_reg;

endmodule

>>> src/dltr_emit.sv
// Output stage: clipping, framebuffer index and the result register.
module dltr_emit import dltr_pkg::*; #(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int MAX_DIM    = MAX_DIM_DEF
) (
    input  logic                                 aclk,
    input  logic                                 aresetn,
    input  logic [$clog2(MAX_DIM + 1)-1:0]       scr_width,
    input  logic [$clog2(MAX_DIM + 1)-1:0]       scr_height,
    input  logic                                 p1_valid,
    input  logic signed [COORD_BITS-1:0]         p1_x,
    input  logic signed [COORD_BITS-1:0]         p1_y,
    input  logic [COLOR_BITS-1:0]                p1_color,
    input  logic                                 p1_last,
    output logic                                 p1_take,
    output logic                                 m_valid,
    input  logic                                 m_ready,
    output logic signed [COORD_BITS-1:0]         m_pixel_x,
    output logic signed [COORD_BITS-1:0]         m_pixel_y,
    output logic [INDEX_BITS-1:0]                m_pixel_index,
    output logic [COLOR_BITS-1:0]                m_pixel_color,
    output logic                                 m_write_enable,
    output logic                                 m_last
);

    localparam int DIM_BITS = $clog2(MAX_DIM + 1);
    localparam int EW       = COORD_BITS + DIM_BITS + 1;
    localparam int PW       = 2 * DIM_BITS + 1;

    logic signed [EW-1:0]     px_w, py_w, w_w, h_w;
    logic [PW-1:0]            sum;
    logic                     we;
    logic [INDEX_BITS-1:0]    idx;

    logic                     m_valid_reg;
    logic signed [COORD_BITS-1:0] x_reg, y_reg;
    logic [INDEX_BITS-1:0]    index_reg;
    logic [COLOR_BITS-1:0]    color_reg;
    logic                     we_reg, last_reg;

    assign px_w = EW'(p1_x);
    assign py_w = EW'(p1_y);
    assign w_w  = signed'(EW'(scr_width));
    assign h_w  = signed'(EW'(scr_height));
    assign we   = (px_w >= 0) && (px_w < w_w) && (py_w >= 0) && (py_w < h_w);
    assign sum  = PW'(scr_width) * PW'(py_w[DIM_BITS-1:0]) + PW'(px_w[DIM_BITS-1:0]);
    assign idx  = we ? INDEX_BITS'(sum) : '0;

    assign p1_take = p1_valid && (!m_valid_reg || m_ready);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (p1_take) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (p1_take) begin
            x_reg     <= p1_x;
            y_reg     <= p1_y;
            index_reg <= idx;
            color_reg <= p1_color;
            we_reg    <= we;
            last_reg  <= p1_last;
        end
    end

    assign m_valid        = m_valid_reg;
    assign m_pixel_x      = x_reg;
    assign m_pixel_y      = y_reg;
    assign m_pixel_index  = index_reg;
    assign m_pixel_color  = color_reg;
    assign m_write_enable = we_reg;
    assign m_last         = last_reg;

endmodule

>>> src/dda_line_triangle_rasterizer.sv
// DDA line and triangle rasterizer: top level with screen size registers.
// Tick beats: one pixel per cycle while m_ready holds and no edge load stalls the
// back end; each result is registered in the queue, the p1 stage and the m_ outputs.
// Each edge load (start beat, or the tick ending a triangle edge) stalls the back end
// for the setup state plus the bit-serial divider; a zero-length edge skips the divider.
// Reset: synchronous, active low; queue, sequencer and output empty, screen 800x600.
module dda_line_triangle_rasterizer import dltr_pkg::*; #(
    parameter int COORD_BITS = COORD_BITS_DEF,
    parameter int FRAC_BITS  = FRAC_BITS_DEF,
    parameter int MAX_DIM    = MAX_DIM_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [KIND_BITS-1:0]          s_kind,
    input  logic signed [COORD_BITS-1:0]  s_ax,
    input  logic signed [COORD_BITS-1:0]  s_ay,
    input  logic signed [COORD_BITS-1:0]  s_bx,
    input  logic signed [COORD_BITS-1:0]  s_by,
    input  logic signed [COORD_BITS-1:0]  s_cx,
    input  logic signed [COORD_BITS-1:0]  s_cy,
    input  logic [COLOR_BITS-1:0]         s_paint,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic signed [COORD_BITS-1:0]  m_pixel_x,
    output logic signed [COORD_BITS-1:0]  m_pixel_y,
    output logic [INDEX_BITS-1:0]         m_pixel_index,
    output logic [COLOR_BITS-1:0]         m_pixel_color,
    output logic                          m_write_enable,
    output logic                          m_last,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [CFG_INDEX_BITS-1:0]     cfg_index,
    input  logic [CFG_DATA_BITS-1:0]      cfg_data
);

    localparam int DIM_BITS = $clog2(MAX_DIM + 1);
    localparam logic [DIM_BITS-1:0] WIDTH_INIT =
        DIM_BITS'((WIDTH_RESET > MAX_DIM) ? MAX_DIM : WIDTH_RESET);
    localparam logic [DIM_BITS-1:0] HEIGHT_INIT =
        DIM_BITS'((HEIGHT_RESET > MAX_DIM) ? MAX_DIM : HEIGHT_RESET);

    logic [DIM_BITS-1:0]          width_reg, height_reg, cfg_sat;
    logic [5:0][COORD_BITS-1:0]   s_vtx, head_vtx;
    q_head_t                      head;
    logic [COLOR_BITS-1:0]        head_paint;
    logic                         head_pop;
    logic                         div_start, div_done;
    logic [COORD_BITS-1:0]        div_mag_x, div_mag_y, div_n;
    logic [FRAC_BITS:0]           div_q_x, div_q_y;
    logic                         p1_valid, p1_last, p1_take;
    logic signed [COORD_BITS-1:0] p1_x, p1_y;
    logic [COLOR_BITS-1:0]        p1_color;

    assign cfg_ready = 1'b1;
    assign cfg_sat   = (32'(cfg_data) > 32'(MAX_DIM)) ? DIM_BITS'(MAX_DIM) : DIM_BITS'(cfg_data);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  <= WIDTH_INIT;
            height_reg <= HEIGHT_INIT;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_SCREEN_WIDTH:  width_reg  <= cfg_sat;
                REG_SCREEN_HEIGHT: height_reg <= cfg_sat;
                default: ;
            endcase
        end
    end

    assign s_vtx = {s_cy, s_cx, s_by, s_bx, s_ay, s_ax};

    dltr_front #(
        .COORD_BITS (COORD_BITS)
    ) u_front (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_valid    (s_valid),
        .s_ready    (s_ready),
        .s_kind     (s_kind),
        .s_vtx      (s_vtx),
        .s_paint    (s_paint),
        .head_pop   (head_pop),
        .head       (head),
        .head_vtx   (head_vtx),
        .head_paint (head_paint)
    );

    dltr_div #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .mag_x   (div_mag_x),
        .mag_y   (div_mag_y),
        .divisor (div_n),
        .done    (div_done),
        .q_x     (div_q_x),
        .q_y     (div_q_y)
    );

    dltr_core #(
        .COORD_BITS (COORD_BITS),
        .FRAC_BITS  (FRAC_BITS)
    ) u_core (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .head       (head),
        .head_vtx   (head_vtx),
        .head_paint (head_paint),
        .head_pop   (head_pop),
        .div_start  (div_start),
        .div_mag_x  (div_mag_x),
        .div_mag_y  (div_mag_y),
        .div_n      (div_n),
        .div_done   (div_done),
        .div_q_x    (div_q_x),
        .div_q_y    (div_q_y),
        .p1_valid   (p1_valid),
        .p1_x       (p1_x),
        .p1_y       (p1_y),
        .p1_color   (p1_color),
        .p1_last    (p1_last),
        .p1_take    (p1_take)
    );

    dltr_emit #(
        .COORD_BITS (COORD_BITS),
        .MAX_DIM    (MAX_DIM)
    ) u_emit (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .scr_width      (width_reg),
        .scr_height     (height_reg),
        .p1_valid       (p1_valid),
        .p1_x           (p1_x),
        .p1_y           (p1_y),
        .p1_color       (p1_color),
        .p1_last        (p1_last),
        .p1_take        (p1_take),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_pixel_x      (m_pixel_x),
        .m_pixel_y      (m_pixel_y),
        .m_pixel_index  (m_pixel_index),
        .m_pixel_color  (m_pixel_color),
        .m_write_enable (m_write_enable),
        .m_last         (m_last)
    );

endmodule

>>> test/tb_dda_line_triangle_rasterizer.sv
// Self-checking testbench for the DDA line and triangle rasterizer with random handshake gaps.
`timescale 1ns / 1ps

module tb_dda_line_triangle_rasterizer;
    import dltr_pkg::*;

    localparam logic [KIND_BITS-1:0] KIND_UNUSED = 2'd3;
    localparam int CB = COORD_BITS_DEF;
    localparam int QUIET_CYCLES = 2 * (FRAC_BITS_DEF + 3) + 8;

    typedef struct {
        logic signed [CB-1:0]   x;
        logic signed [CB-1:0]   y;
        logic [INDEX_BITS-1:0]  index;
        logic [COLOR_BITS-1:0]  color;
        logic                   we;
        logic                   last;
    } pixel_t;

    logic                      aclk;
    logic                      aresetn = 1'b0;
    logic                      s_valid = 1'b0;
    logic                      s_ready;
    logic [KIND_BITS-1:0]      s_kind = '0;
    logic signed [CB-1:0]      s_ax = '0;
    logic signed [CB-1:0]      s_ay = '0;
    logic signed [CB-1:0]      s_bx = '0;
    logic signed [CB-1:0]      s_by = '0;
    logic signed [CB-1:0]      s_cx = '0;
    logic signed [CB-1:0]      s_cy = '0;
    logic [COLOR_BITS-1:0]     s_paint = '0;
    logic                      m_valid;
    logic                      m_ready = 1'b0;
    logic signed [CB-1:0]      m_pixel_x;
    logic signed [CB-1:0]      m_pixel_y;
    logic [INDEX_BITS-1:0]     m_pixel_index;
    logic [COLOR_BITS-1:0]     m_pixel_color;
    logic                      m_write_enable;
    logic                      m_last;
    logic                      cfg_valid = 1'b0;
    logic                      cfg_ready;
    logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
    logic [CFG_DATA_BITS-1:0]  cfg_data = '0;

    // predictor state
    int         scr_width = WIDTH_RESET;
    int         scr_height = HEIGHT_RESET;
    bit         drawing = 1'b0;
    longint     pos_x = 0;
    longint     pos_y = 0;
    longint     step_x = 0;
    longint     step_y = 0;
    longint     steps_to_go = 0;
    logic [1:0] cur_edge = EDGE_AB;
    longint     corner [6];
    logic [COLOR_BITS-1:0] ink = '0;

    pixel_t pending_pixels [$];
    pixel_t due;
    int     errors = 0;
    int     beats_sent = 0;
    int     stall_left = 0;
    bit     no_idle = 1'b0;

    dda_line_triangle_rasterizer i_dut (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .s_valid        (s_valid),
        .s_ready        (s_ready),
        .s_kind         (s_kind),
        .s_ax           (s_ax),
        .s_ay           (s_ay),
        .s_bx           (s_bx),
        .s_by           (s_by),
        .s_cx           (s_cx),
        .s_cy           (s_cy),
        .s_paint        (s_paint),
        .m_valid        (m_valid),
        .m_ready        (m_ready),
        .m_pixel_x      (m_pixel_x),
        .m_pixel_y      (m_pixel_y),
        .m_pixel_index  (m_pixel_index),
        .m_pixel_color  (m_pixel_color),
        .m_write_enable (m_write_enable),
        .m_last         (m_last),
        .cfg_valid      (cfg_valid),
        .cfg_ready      (cfg_ready),
        .cfg_index      (cfg_index),
        .cfg_data       (cfg_data)
    );

    initial begin
        aclk = 1'b0;
        forever #6 aclk = ~aclk;
    end

    initial begin
        #(10_000_000);
        $display("dda_line_triangle_rasterizer verification failed");
        $finish;
    end

    task automatic report_mismatch(input string what);
        $display("%0t ns: %s", $time, what);
        errors++;
    endtask

    function automatic longint round_half_away(input longint a);
        longint half;
        half = longint'(1) <<< (FRAC_BITS_DEF - 1);
        if (a >= 0) begin
            return (a + half) >>> FRAC_BITS_DEF;
        end
        return -((-a + half) >>> FRAC_BITS_DEF);
    endfunction

    function automatic void load_segment(input longint x0, input longint y0,
                                         input longint x1, input longint y1);
        longint dx, dy, adx, ady, n;
        dx = x1 - x0;
        dy = y1 - y0;
        adx = dx < 0 ? -dx : dx;
        ady = dy < 0 ? -dy : dy;
        n = adx > ady ? adx : ady;
        pos_x = x0 <<< FRAC_BITS_DEF;
        pos_y = y0 <<< FRAC_BITS_DEF;
        if (n == 0) begin
            step_x = 0;
            step_y = 0;
        end else begin
            step_x = (dx <<< FRAC_BITS_DEF) / n;
            step_y = (dy <<< FRAC_BITS_DEF) / n;
        end
        steps_to_go = n;
    endfunction

    function automatic void load_edge_number();
        case (cur_edge)
            EDGE_AB: load_segment(corner[0], corner[1], corner[2], corner[3]);
            EDGE_BC: load_segment(corner[2], corner[3], corner[4], corner[5]);
            default: load_segment(corner[4], corner[5], corner[0], corner[1]);
        endcase
    endfunction

    // advances the predicted rasterizer by one accepted beat
    function automatic void raster_step(input logic [KIND_BITS-1:0] k,
                                        input logic signed [CB-1:0] ax, ay, bx, by, cx, cy,
                                        input logic [COLOR_BITS-1:0] p);
        longint px, py;
        pixel_t e;
        if (k == KIND_LINE || k == KIND_TRI) begin
            corner[0] = ax;
            corner[1] = ay;
            corner[2] = bx;
            corner[3] = by;
            corner[4] = cx;
            corner[5] = cy;
            ink = p;
            if (k == KIND_LINE) begin
                cur_edge = EDGE_CA;
                load_segment(corner[0], corner[1], corner[2], corner[3]);
            end else begin
                cur_edge = EDGE_AB;
                load_edge_number();
            end
            drawing = 1'b1;
            return;
        end
        if (k != KIND_TICK || !drawing) begin
            return;
        end
        px = round_half_away(pos_x);
        py = round_half_away(pos_y);
        e.we = px >= 0 && px < scr_width && py >= 0 && py < scr_height;
        e.index = e.we ? INDEX_BITS'(scr_width * py + px) : '0;
        e.x = px[CB-1:0];
        e.y = py[CB-1:0];
        e.color = ink;
        e.last = 1'b0;
        if (steps_to_go > 0) begin
            pos_x += step_x;
            pos_y += step_y;
            steps_to_go--;
        end else if (cur_edge != EDGE_CA) begin
            cur_edge++;
            load_edge_number();
        end else begin
            drawing = 1'b0;
            e.last = 1'b1;
        end
        pending_pixels.push_back(e);
    endfunction

    // valid stays high after acceptance; the next call either reloads it or drops it
    task automatic send_beat(input logic [KIND_BITS-1:0] k,
                             input logic signed [CB-1:0] ax, ay, bx, by, cx, cy,
                             input logic [COLOR_BITS-1:0] p);
        int gap;
        gap = no_idle ? 0 : $urandom_range(0, 17);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_kind  <= k;
        s_ax    <= ax;
        s_ay    <= ay;
        s_bx    <= bx;
        s_by    <= by;
        s_cx    <= cx;
        s_cy    <= cy;
        s_paint <= p;
        do @(posedge aclk); while (!s_ready);
        raster_step(k, ax, ay, bx, by, cx, cy, p);
        if (k != KIND_UNUSED) begin
            beats_sent++;
        end
    endtask

    task automatic send_tick();
        send_beat(KIND_TICK, $urandom_range(0, 65535), $urandom_range(0, 65535),
                  $urandom_range(0, 65535), $urandom_range(0, 65535),
                  $urandom_range(0, 65535), $urandom_range(0, 65535), $urandom());
    endtask

    task automatic send_ticks(input int count);
        while (count > 0 && drawing) begin
            send_tick();
            count--;
        end
    endtask

    task automatic run_line(input logic signed [CB-1:0] ax, ay, bx, by);
        send_beat(KIND_LINE, ax, ay, bx, by, $urandom_range(0, 65535),
                  $urandom_range(0, 65535), $urandom());
        send_ticks(1 << 30);
    endtask

    task automatic wait_quiet();
        s_valid <= 1'b0;
        while (pending_pixels.size() != 0) @(posedge aclk);
        repeat (QUIET_CYCLES) @(posedge aclk);
    endtask

    task automatic write_reg(input logic [CFG_INDEX_BITS-1:0] idx,
                             input logic [CFG_DATA_BITS-1:0] val);
        int v;
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        v = val > MAX_DIM_DEF ? MAX_DIM_DEF : int'(val);
        if (idx == REG_SCREEN_WIDTH) begin
            scr_width = v;
        end else begin
            scr_height = v;
        end
    endtask

    task automatic set_screen(input logic [CFG_DATA_BITS-1:0] w, h);
        wait_quiet();
        write_reg(REG_SCREEN_WIDTH, w);
        write_reg(REG_SCREEN_HEIGHT, h);
    endtask

    task automatic test_reset_screen();
        send_tick();
        send_beat(KIND_UNUSED, 16'sh7fff, 16'sh8000, 16'sh7fff, 16'sh8000,
                  16'sh5a5a, 16'sha5a5, 32'hdead_beef);
        run_line(799, 599, 801, 601);
        run_line(5, 7, 5, 7);
        // positive and negative half-pixel rounding
        send_beat(KIND_TRI, 0, 0, 2, 1, -1, -2, 32'h80ff_00ff);
        send_ticks(1 << 30);
        // restart while busy, full-range coordinates
        send_beat(KIND_LINE, -32768, -32768, 32767, 32767, 32767, -32768, 32'hffff_ffff);
        send_ticks(2);
        send_beat(KIND_LINE, 32767, -32768, -32768, 32767, 0, 0, 32'h0);
        send_ticks(1);
        run_line(-3, -4, -3, -4);
    endtask

    task automatic test_register_extremes();
        set_screen(1, 1);
        run_line(-1, -1, 1, 1);
        set_screen(4096, 4096);
        run_line(4094, 4094, 4097, 4097);
        set_screen(0, 0);
        run_line(0, 0, 1, 0);
        set_screen(8191, 4097);
        run_line(4095, 4095, 4096, 4097);
    endtask

    task automatic random_primitive();
        logic signed [CB-1:0] v [6];
        int anchor_x, anchor_y, mode, ticks;
        logic [KIND_BITS-1:0] k;
        mode = $urandom_range(0, 9);
        anchor_x = 0;
        anchor_y = 0;
        case (mode)
            2, 3: begin
                anchor_x = scr_width;
                anchor_y = scr_height;
            end
            4: anchor_x = scr_width;
            5: anchor_y = scr_height;
            6, 7, 8: begin
                anchor_x = $urandom_range(0, scr_width);
                anchor_y = $urandom_range(0, scr_height);
            end
            default: ;
        endcase
        k = $urandom_range(0, 1) ? KIND_TRI : KIND_LINE;
        for (int i = 0; i < 6; i++) begin
            if (mode == 9 || (k == KIND_LINE && i >= 4)) begin
                v[i] = $urandom_range(0, 65535);
            end else begin
                v[i] = CB'((i % 2 ? anchor_y : anchor_x) + int'($urandom_range(0, 24)) - 12);
            end
        end
        send_beat(k, v[0], v[1], v[2], v[3], v[4], v[5], $urandom());
        if (mode == 9) begin
            ticks = $urandom_range(1, 40);
        end else if ($urandom_range(0, 9) == 0) begin
            ticks = $urandom_range(0, 30);
        end else begin
            ticks = 1 << 30;
        end
        send_ticks(ticks);
    endtask

    task automatic random_phase(input logic [CFG_DATA_BITS-1:0] w, h, input int count);
        int target, r;
        set_screen(w, h);
        target = beats_sent + count;
        while (beats_sent < target) begin
            r = $urandom_range(0, 99);
            if ($urandom_range(0, 19) == 0) begin
                no_idle = $urandom_range(0, 3) == 0;
            end
            if (r < 4) begin
                send_beat(KIND_UNUSED, $urandom_range(0, 65535), $urandom_range(0, 65535),
                          $urandom_range(0, 65535), $urandom_range(0, 65535),
                          $urandom_range(0, 65535), $urandom_range(0, 65535), $urandom());
            end else if (r < 9) begin
                send_tick();
            end else begin
                random_primitive();
            end
        end
        no_idle = 1'b0;
    endtask

    task automatic test_random();
        random_phase($urandom_range(1, 4096), $urandom_range(1, 4096), 300);
        random_phase(4096, 4096, 300);
        random_phase($urandom_range(1, 64), $urandom_range(1, 64), 300);
        random_phase($urandom_range(0, 8191), $urandom_range(0, 8191), 300);
        random_phase(WIDTH_RESET, HEIGHT_RESET, 300);
    endtask

    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (pending_pixels.size() == 0) begin
                    report_mismatch("pixel beat with nothing pending");
                end else begin
                    due = pending_pixels.pop_front();
                    if (m_pixel_x !== due.x)
                        report_mismatch($sformatf("pixel_x got %0d want %0d", m_pixel_x, due.x));
                    if (m_pixel_y !== due.y)
                        report_mismatch($sformatf("pixel_y got %0d want %0d", m_pixel_y, due.y));
                    if (m_pixel_index !== due.index)
                        report_mismatch($sformatf("pixel_index got %0d want %0d",
                                                  m_pixel_index, due.index));
                    if (m_pixel_color !== due.color)
                        report_mismatch($sformatf("pixel_color got %h want %h",
                                                  m_pixel_color, due.color));
                    if (m_write_enable !== due.we)
                        report_mismatch($sformatf("write_enable got %b want %b",
                                                  m_write_enable, due.we));
                    if (m_last !== due.last)
                        report_mismatch($sformatf("last got %b want %b", m_last, due.last));
                end
                stall_left = no_idle ? 0 : $urandom_range(0, 17);
                if (stall_left > 0) begin
                    m_ready <= 1'b0;
                end
            end else if (!m_ready) begin
                if (stall_left <= 1) begin
                    m_ready <= 1'b1;
                end
                stall_left = stall_left > 0 ? stall_left - 1 : 0;
            end
        end
    end

    initial begin
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;
        test_reset_screen();
        test_register_extremes();
        test_random();
        wait_quiet();
        if (errors == 0) begin
            $display("dda_line_triangle_rasterizer verification clean");
        end else begin
            $display("dda_line_triangle_rasterizer verification failed");
        end
        $finish;
    end

endmodule
